>>> rtl/ppmdec_pkg.sv
// Shared types, codes and constants for the PWM-to-ppm decoder.
`timescale 1ns / 1ps

package ppmdec_pkg;

    localparam int TIME_BITS_DEF = 24;
    localparam int TIMEOUT_W     = 24;
    localparam int PPM_W         = 14;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 24;
    localparam int QDEPTH        = 2;
    localparam int QPTR_W        = 1;
    localparam int QCNT_W        = 2;

    localparam int HIGH_OFS = 2000;
    localparam int SUM_OFS  = 4000;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 24'd1500000;
    localparam logic [PPM_W-1:0]     RANGE_RST   = 14'd5000;

    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE   = 2'd1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_BAD     = 2'd2;

    typedef struct packed {
        logic pin_level;
        logic start_req;
    } tick_t;

    typedef struct packed {
        logic             done_res;
        logic [1:0]       status;
        logic [PPM_W-1:0] ppm;
    } result_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WAIT_LOW,
        PH_WAIT_RISE,
        PH_HIGH,
        PH_LOW
    } phase_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_CHECK,
        B_DIV
    } bstate_t;

    typedef enum logic {
        JOB_TIMEOUT,
        JOB_MEASURE
    } job_kind_t;

    typedef struct packed {
        logic      push;
        job_kind_t kind;
    } job_ctl_t;

endpackage

>>> rtl/ppmdec_front.sv
// Front end: edge tracking, level timing and timeout detection per tick.
`timescale 1ns / 1ps

module ppmdec_front #(
    parameter int TIME_BITS = ppmdec_pkg::TIME_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             tick_accept,
    input  ppmdec_pkg::tick_t                tick,
    input  logic [ppmdec_pkg::TIMEOUT_W-1:0] timeout_lim,
    output ppmdec_pkg::job_ctl_t             job_ctl,
    output logic [TIME_BITS-1:0]             job_high,
    output logic [TIME_BITS-1:0]             job_low
);
    import ppmdec_pkg::*;

    localparam int CMP_W = (TIME_BITS > TIMEOUT_W) ? TIME_BITS : TIMEOUT_W;

    phase_t                 phase_reg, phase_next;
    logic [TIME_BITS-1:0]   wait_reg, wait_next;
    logic [TIME_BITS-1:0]   high_reg, high_next;
    logic [TIME_BITS-1:0]   low_reg, low_next;
    logic [TIME_BITS-1:0]   wait_inc;
    logic                   timed_out;

    function automatic logic [TIME_BITS-1:0] sat_inc(input logic [TIME_BITS-1:0] v);
        sat_inc = (v == {TIME_BITS{1'b1}}) ? v : v + 1'b1;
    endfunction

    assign wait_inc  = sat_inc(wait_reg);
    assign timed_out = CMP_W'(wait_inc) > CMP_W'(timeout_lim);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            wait_reg  <= '0;
            high_reg  <= '0;
            low_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            wait_reg  <= wait_next;
            high_reg  <= high_next;
            low_reg   <= low_next;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        wait_next    = wait_reg;
        high_next    = high_reg;
        low_next     = low_reg;
        job_ctl.push = 1'b0;
        job_ctl.kind = JOB_TIMEOUT;
        if (tick_accept)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (tick.start_req)
                    begin
                        phase_next = PH_WAIT_LOW;
                        wait_next  = '0;
                        high_next  = '0;
                        low_next   = '0;
                    end
                end
                PH_WAIT_LOW:
                begin
                    if (!tick.pin_level)
                    begin
                        phase_next = PH_WAIT_RISE;
                        wait_next  = '0;
                    end
                    else
                    begin
                        wait_next = wait_inc;
                        if (timed_out)
                        begin
                            job_ctl.push = 1'b1;
                            phase_next   = PH_IDLE;
                        end
                    end
                end
                PH_WAIT_RISE:
                begin
                    if (tick.pin_level)
                    begin
                        phase_next = PH_HIGH;
                        wait_next  = '0;
                        high_next  = TIME_BITS'(1);
                    end
                    else
                    begin
                        wait_next = wait_inc;
                        if (timed_out)
                        begin
                            job_ctl.push = 1'b1;
                            phase_next   = PH_IDLE;
                        end
                    end
                end
                PH_HIGH:
                begin
                    if (!tick.pin_level)
                    begin
                        phase_next = PH_LOW;
                        wait_next  = '0;
                        low_next   = TIME_BITS'(1);
                    end
                    else
                    begin
                        high_next = sat_inc(high_reg);
                        wait_next = wait_inc;
                        if (timed_out)
                        begin
                            job_ctl.push = 1'b1;
                            phase_next   = PH_IDLE;
                        end
                    end
                end
                PH_LOW:
                begin
                    if (tick.pin_level)
                    begin
                        job_ctl.push = 1'b1;
                        job_ctl.kind = JOB_MEASURE;
                        phase_next   = PH_IDLE;
                    end
                    else
                    begin
                        low_next  = sat_inc(low_reg);
                        wait_next = wait_inc;
                        if (timed_out)
                        begin
                            job_ctl.push = 1'b1;
                            phase_next   = PH_IDLE;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    assign job_high = high_reg;
    assign job_low  = low_reg;

endmodule

>>> rtl/ppmdec_queue.sv
// Two-entry job queue between the tick front end and the ppm back end.
`timescale 1ns / 1ps

module ppmdec_queue #(
    parameter int W = 2 * ppmdec_pkg::TIME_BITS_DEF + 1
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    input  logic         pop,
    output logic         full,
    output logic         not_empty,
    output logic [W-1:0] head
);
    import ppmdec_pkg::*;

    logic [W-1:0]        entry_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;

    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue pop while empty");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue count out of range");
`endif

endmodule

>>> rtl/ppmdec_back.sv
// Back end: validity checks, scaling multiply and 14-step restoring division.
`timescale 1ns / 1ps

module ppmdec_back #(
    parameter int TIME_BITS = ppmdec_pkg::TIME_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         job_ready,
    input  ppmdec_pkg::job_kind_t        job_kind,
    input  logic [TIME_BITS-1:0]         job_high,
    input  logic [TIME_BITS-1:0]         job_low,
    output logic                         pop,
    input  logic [ppmdec_pkg::PPM_W-1:0] range_ppm,
    output logic                         out_valid,
    input  logic                         out_stall,
    output ppmdec_pkg::result_t          out_data
);
    import ppmdec_pkg::*;

    localparam int SW = TIME_BITS + 2;
    localparam int PW = TIME_BITS + PPM_W;
    localparam int CW = $clog2(PPM_W);

    bstate_t                state_reg, state_next;
    job_kind_t              kind_reg;
    logic [TIME_BITS-1:0]   high_reg, low_reg;
    logic [PW-1:0]          rem_reg, rem_next;
    logic [PW-1:0]          div_reg, div_next;
    logic [PPM_W-1:0]       quo_reg, quo_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   out_valid_reg, out_valid_next;
    result_t                out_data_reg, out_data_next;

    logic signed [SW-1:0]   num_s, den_s;
    logic [TIME_BITS-1:0]   num_u;
    logic [PW-1:0]          prod;
    logic [PW:0]            diff;
    logic                   bad;
    logic                   out_free;

    assign num_s = $signed({2'b00, high_reg}) - $signed(SW'(HIGH_OFS));
    assign den_s = $signed({2'b00, high_reg}) + $signed({2'b00, low_reg})
                   - $signed(SW'(SUM_OFS));
    assign num_u = num_s[TIME_BITS-1:0];
    assign prod  = {{TIME_BITS{1'b0}}, range_ppm} * {{PPM_W{1'b0}}, num_u};
    assign bad   = (high_reg == '0) || (low_reg == '0) || (den_s <= 0);
    assign diff  = {1'b0, rem_reg} - {1'b0, div_reg};

    assign out_free = !out_valid_reg || !out_stall;
    assign pop      = (state_reg == B_IDLE) && job_ready && out_free;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg <= job_kind;
            high_reg <= job_high;
            low_reg  <= job_low;
        end
        rem_reg      <= rem_next;
        div_reg      <= div_next;
        quo_reg      <= quo_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        div_next       = div_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            B_IDLE:
            begin
                if (pop)
                begin
                    state_next = B_CHECK;
                end
            end
            B_CHECK:
            begin
                state_next             = B_IDLE;
                out_valid_next         = 1'b1;
                out_data_next.done_res = 1'b1;
                out_data_next.status   = ST_OK;
                out_data_next.ppm      = '0;
                if (kind_reg == JOB_TIMEOUT)
                begin
                    out_data_next.status = ST_TIMEOUT;
                end
                else if (bad)
                begin
                    out_data_next.status = ST_BAD;
                end
                else if (num_s <= 0)
                begin
                    out_data_next.ppm = '0;
                end
                else if (num_s >= den_s)
                begin
                    // quotient reaches full scale: clamp
                    out_data_next.ppm = range_ppm;
                end
                else
                begin
                    // quotient fits in PPM_W bits, so start with divisor << (PPM_W-1)
                    out_valid_next = 1'b0;
                    state_next     = B_DIV;
                    rem_next       = prod;
                    div_next       = PW'(den_s[TIME_BITS:0]) << (PPM_W - 1);
                    quo_next       = '0;
                    cnt_next       = CW'(PPM_W - 1);
                end
            end
            B_DIV:
            begin
                if (!diff[PW])
                begin
                    rem_next = diff[PW-1:0];
                end
                quo_next = {quo_reg[PPM_W-2:0], !diff[PW]};
                div_next = div_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next             = B_IDLE;
                    out_valid_next         = 1'b1;
                    out_data_next.done_res = 1'b1;
                    out_data_next.status   = ST_OK;
                    out_data_next.ppm      = {quo_reg[PPM_W-2:0], !diff[PW]};
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef ASSERT_OFF
    a_pop_free: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !(out_valid_reg && out_stall))
        else $error("job taken while result register is blocked");
    a_div_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_DIV) |-> (!out_valid_reg || $past(state_reg) != B_DIV))
        else $error("result register busy during division");
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.status != ST_OK) |-> (out_data_reg.ppm == '0))
        else $error("failed measurement carries nonzero ppm");
`endif

endmodule

>>> rtl/pwm_pulse_to_ppm_decoder_top.sv
// Top level of the PWM-to-ppm decoder: config registers, front, queue, back.
//
//  port group   dir  transfer when           payload
//  in_*         in   in_valid && !in_stall   tick_t   {pin_level, start_req}
//  out_*        out  out_valid && !out_stall result_t {done_res, status, ppm}
//  cfg_*        in   cfg_we                  cfg_index selects register, cfg_data
//
// One tick is taken per cycle while the two-entry job queue has room.
// Timeouts, bad timing and clamped values are resolved in the check state;
// other results come from the 14-step restoring divider that follows it.
// Reset clears the phase machine, queue and result valid; no clearing pass.
// in_stall is high only while the job queue is full; out_stall only holds
// the result register and, through the queue, the input.
`timescale 1ns / 1ps

module pwm_pulse_to_ppm_decoder_top #(
    parameter int TIME_BITS = ppmdec_pkg::TIME_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  ppmdec_pkg::tick_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output ppmdec_pkg::result_t               out_data,
    input  logic                              cfg_we,
    input  logic [ppmdec_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ppmdec_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ppmdec_pkg::*;

    localparam int JW = 2 * TIME_BITS + 1;

    logic [TIMEOUT_W-1:0]  timeout_reg;
    logic [PPM_W-1:0]      range_reg;

    job_ctl_t              job_ctl;
    logic [TIME_BITS-1:0]  job_high, job_low;
    logic [JW-1:0]         q_head;
    logic                  q_full, q_not_empty, q_pop;
    job_kind_t             head_kind;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RST;
            range_reg   <= RANGE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TIMEOUT: timeout_reg <= cfg_data[TIMEOUT_W-1:0];
                REG_RANGE:   range_reg   <= cfg_data[PPM_W-1:0];
                default:     ;
            endcase
        end
    end

    assign in_stall = q_full;

    ppmdec_front #(
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick_accept (in_valid && !in_stall),
        .tick        (in_data),
        .timeout_lim (timeout_reg),
        .job_ctl     (job_ctl),
        .job_high    (job_high),
        .job_low     (job_low)
    );

    ppmdec_queue #(
        .W (JW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_ctl.push),
        .push_data ({job_ctl.kind, job_high, job_low}),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    assign head_kind = job_kind_t'(q_head[JW-1]);

    ppmdec_back #(
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_ready (q_not_empty),
        .job_kind  (head_kind),
        .job_high  (q_head[2*TIME_BITS-1:TIME_BITS]),
        .job_low   (q_head[TIME_BITS-1:0]),
        .pop       (q_pop),
        .range_ppm (range_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

>>> tb/sv/testbench.sv
// Testbench for the PWM-to-ppm decoder: directed and random pulse trains, results checked in order.
`timescale 1ns / 1ps

module testbench;
    import ppmdec_pkg::*;

    localparam int CW = TIME_BITS_DEF;
    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_MAX = {TIMEOUT_W{1'b1}};
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_REPORTS = 10;
    localparam longint LIMIT_NS = 64'd40_000_000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    tick_t                 in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    result_t               out_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // behavioral copy of the decoder
    phase_t               dec_phase = PH_IDLE;
    logic [CW-1:0]        dec_wait = '0;
    logic [CW-1:0]        dec_high = '0;
    logic [CW-1:0]        dec_low = '0;
    logic [TIMEOUT_W-1:0] cfg_timeout = TIMEOUT_RST;
    logic [PPM_W-1:0]     cfg_range = RANGE_RST;

    result_t pending_results[$];
    int      fail_count = 0;
    int      busy_ticks = 0;
    bit      ragged = 1'b1;
    int      hold_left = 0;

    pwm_pulse_to_ppm_decoder_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic logic [CW-1:0] bump(input logic [CW-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic bit wait_expired();
        dec_wait = bump(dec_wait);
        return dec_wait > cfg_timeout;
    endfunction

    function automatic result_t closing_result();
        longint hi;
        longint lo;
        longint num;
        longint den;
        longint q;
        hi = longint'(dec_high);
        lo = longint'(dec_low);
        num = hi - HIGH_OFS;
        den = hi + lo - SUM_OFS;
        if (hi == 0 || lo == 0 || den <= 0)
            return result_t'{1'b1, ST_BAD, {PPM_W{1'b0}}};
        q = (longint'(cfg_range) * num) / den;
        if (q < 0)
            q = 0;
        if (q > longint'(cfg_range))
            q = longint'(cfg_range);
        return result_t'{1'b1, ST_OK, q[PPM_W-1:0]};
    endfunction

    task automatic advance_decoder(input tick_t t);
        bit      done;
        result_t r;
        done = 1'b0;
        r = result_t'{1'b1, ST_TIMEOUT, {PPM_W{1'b0}}};
        if (dec_phase != PH_IDLE || t.start_req)
            busy_ticks++;
        case (dec_phase)
            PH_IDLE:
                if (t.start_req)
                begin
                    dec_phase = PH_WAIT_LOW;
                    dec_wait = '0;
                    dec_high = '0;
                    dec_low = '0;
                end
            PH_WAIT_LOW:
                if (!t.pin_level)
                begin
                    dec_phase = PH_WAIT_RISE;
                    dec_wait = '0;
                end
                else
                    done = wait_expired();
            PH_WAIT_RISE:
                if (t.pin_level)
                begin
                    dec_phase = PH_HIGH;
                    dec_wait = '0;
                    dec_high = CW'(1);
                end
                else
                    done = wait_expired();
            PH_HIGH:
                if (!t.pin_level)
                begin
                    dec_phase = PH_LOW;
                    dec_wait = '0;
                    dec_low = CW'(1);
                end
                else
                begin
                    dec_high = bump(dec_high);
                    done = wait_expired();
                end
            PH_LOW:
                if (t.pin_level)
                begin
                    r = closing_result();
                    done = 1'b1;
                end
                else
                begin
                    dec_low = bump(dec_low);
                    done = wait_expired();
                end
            default:
                dec_phase = PH_IDLE;
        endcase
        if (done)
        begin
            pending_results.push_back(r);
            dec_phase = PH_IDLE;
        end
    endtask

    function automatic void flag_mismatch(input string what, input result_t want,
                                          input result_t got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("mismatch (%s) at %0t: want %0b/%0d/%0d got %0b/%0d/%0d",
                     what, $time, want.done_res, want.status, want.ppm,
                     got.done_res, got.status, got.ppm);
    endfunction

    // result checker and receiver stall
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                flag_mismatch("unexpected result", '0, out_data);
            else
            begin
                want = pending_results.pop_front();
                if (out_data.done_res !== want.done_res || out_data.status !== want.status ||
                    out_data.ppm !== want.ppm)
                    flag_mismatch("field", want, out_data);
            end
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ragged && ($urandom_range(99) < 34);
    end

    task automatic send_tick(input logic pin, input logic start);
        while (ragged && $urandom_range(99) < 34)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= tick_t'{pin, start};
        do
            @(posedge clk);
        while (in_stall);
        advance_decoder(in_data);
    endtask

    // start, optional early highs, low lead-in, then high_len highs, low_len lows, closing rise
    task automatic measure_pulse(input int pre_hi, input int lead_lo, input int high_len,
                                 input int low_len);
        send_tick(1'($urandom_range(1)), 1'b1);
        repeat (pre_hi) send_tick(1'b1, 1'($urandom_range(1)));
        repeat (lead_lo) send_tick(1'b0, 1'($urandom_range(1)));
        repeat (high_len) send_tick(1'b1, 1'($urandom_range(1)));
        repeat (low_len) send_tick(1'b0, 1'($urandom_range(1)));
        send_tick(1'b1, 1'($urandom_range(1)));
    endtask

    task automatic quiesce();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == REG_TIMEOUT)
            cfg_timeout = val[TIMEOUT_W-1:0];
        else if (idx == REG_RANGE)
            cfg_range = val[PPM_W-1:0];
    endtask

    task automatic pick_config();
        case ($urandom_range(3))
            0: write_reg(REG_TIMEOUT, CFG_DATA_W'($urandom_range(1, 8)));
            1: write_reg(REG_TIMEOUT, CFG_DATA_W'($urandom_range(1, 60)));
            2: write_reg(REG_TIMEOUT, CFG_DATA_W'($urandom_range(3001, 16777215)));
            default: write_reg(REG_TIMEOUT, TIMEOUT_MAX);
        endcase
        case ($urandom_range(3))
            0: write_reg(REG_RANGE, CFG_DATA_W'(1));
            1: write_reg(REG_RANGE, CFG_DATA_W'(10000));
            default: write_reg(REG_RANGE, CFG_DATA_W'($urandom_range(1, 10000)));
        endcase
        if ($urandom_range(3) == 0)
            write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B,
                      CFG_DATA_W'($urandom));
    endtask

    // reset values, no idling on either side
    task automatic test_reset_defaults();
        ragged = 1'b0;
        measure_pulse(0, 1, 2100, 2100);
        quiesce();
        ragged = 1'b1;
    endtask

    task automatic test_wait_timeouts();
        quiesce();
        write_reg(REG_TIMEOUT, CFG_DATA_W'(1));
        write_reg(REG_RANGE, CFG_DATA_W'(10000));
        write_reg(REG_SPARE_A, TIMEOUT_MAX);
        write_reg(REG_SPARE_B, '0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        // timeout waiting for low
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b0);
        // timeout waiting for rise
        send_tick(1'b0, 1'b1);
        repeat (3) send_tick(1'b0, 1'b0);
        // timeout while high
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        repeat (3) send_tick(1'b1, 1'b0);
        // timeout while low
        measure_pulse(0, 1, 1, 3);
        // one-tick high and low: bad timing
        measure_pulse(0, 1, 1, 1);
        // start while busy is ignored
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b1);
        quiesce();
    endtask

    task automatic test_ppm_math();
        quiesce();
        write_reg(REG_TIMEOUT, TIMEOUT_MAX);
        write_reg(REG_RANGE, CFG_DATA_W'(10000));
        measure_pulse(2, 3, 2100, 1950);   // clamps at full scale
        measure_pulse(0, 1, 1990, 2020);   // negative quotient
        measure_pulse(0, 1, 2000, 2000);   // zero denominator
        quiesce();
        write_reg(REG_RANGE, CFG_DATA_W'(7777));
        measure_pulse(1, 2, 2010, 2100);   // divider path
        quiesce();
    endtask

    // receiver holds off while timeouts keep coming, so the input stalls
    task automatic test_backpressure();
        quiesce();
        write_reg(REG_TIMEOUT, CFG_DATA_W'(1));
        hold_left = 300;
        repeat (60)
        begin
            send_tick(1'b1, 1'b1);
            send_tick(1'b1, 1'b0);
            send_tick(1'b1, 1'b0);
        end
        quiesce();
    endtask

    task automatic test_random();
        int busy_base;
        int kind;
        int n;
        busy_base = busy_ticks;
        quiesce();
        pick_config();
        while (busy_ticks - busy_base < 1000)
        begin
            if ($urandom_range(7) == 0)
            begin
                quiesce();
                pick_config();
            end
            kind = $urandom_range(99);
            if (kind < 70)
                measure_pulse($urandom_range(3), $urandom_range(1, 4),
                              $urandom_range(1, 25), $urandom_range(1, 25));
            else
            begin
                n = $urandom_range(1, 20);
                repeat (n) send_tick(1'($urandom_range(1)), $urandom_range(3) == 0);
            end
        end
        quiesce();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_wait_timeouts();
        test_ppm_math();
        test_backpressure();
        test_random();
        if (fail_count == 0 && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> files.f
rtl/ppmdec_pkg.sv
rtl/ppmdec_front.sv
rtl/ppmdec_queue.sv
rtl/ppmdec_back.sv
rtl/pwm_pulse_to_ppm_decoder_top.sv
tb/sv/testbench.sv
